FILE: sv/pbba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pooled block bitmap allocator package
// Sizes, command, status and register codes, and sequencer states shared by
// the allocator.
// ----------------------------------------------------------------------------
package pbba_pkg;

  localparam int NUM_BLOCKS  = 64;
  localparam int NUM_CLIENTS = 16;
  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
  localparam int CLI_W       = $clog2(NUM_CLIENTS);

  localparam logic [6:0] BLOCK_COUNT_RESET = 7'd64;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_NO_SPACE = 1'b1
  } status_t;

  typedef enum logic [1:0] {
    CFG_BLOCK_COUNT = 2'd0,
    CFG_RES_BLOCKS  = 2'd1,
    CFG_RES_CNT_LO  = 2'd2,
    CFG_RES_CNT_HI  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_ALLOC,
    S_COUNT,
    S_DONE
  } state_t;

endpackage : pbba_pkg
`default_nettype wire

FILE: sv/pooled_block_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pooled block bitmap allocator
// A shared pool of blocks is handed out first fit to clients through a used
// bitmap and one bitmap per client. A single bit-test and counter unit walks
// the maps one block per cycle under a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted, the free blocks are counted, the
// allocation walk runs until the need is met or the map ends, the final
// counts are taken and the result is held; a failed request skips the walk,
// and a release clears the client map on acceptance and goes to the count.
// Throughput: one item at a time; the next item is taken once the result
// has been transferred.
// Reset: synchronous active-low rst_n clears all maps and loads register
// defaults; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module pooled_block_bitmap_allocator
  import pbba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input items.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // client[3:0], want_blocks[11:4], zero[15:12]
  input  wire logic [0:0]  in_tuser,  // cmd[0]
  // Result items.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // client_blocks[6:0], free_blocks[13:7], zero[15:14]
  output logic [0:0]       out_tuser, // status[0]
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  state_t                state_r, state_nxt;
  logic [6:0]            block_count_r, block_count_nxt;
  logic [63:0]           res_blocks_r, res_blocks_nxt;
  logic [63:0]           res_cnt_lo_r, res_cnt_lo_nxt;
  logic [63:0]           res_cnt_hi_r, res_cnt_hi_nxt;
  logic [NUM_BLOCKS-1:0] used_r, used_nxt;
  logic [NUM_BLOCKS-1:0] cmap_r [NUM_CLIENTS];
  logic [NUM_BLOCKS-1:0] cmap_nxt [NUM_CLIENTS];
  logic [3:0]            client_r, client_nxt;
  logic                  client_ok_r, client_ok_nxt;
  logic [7:0]            need_r, need_nxt;
  logic [BLK_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]      held_cnt_r, held_cnt_nxt;
  logic                  status_r, status_nxt;

  logic [CNT_W-1:0]      pool_size;
  logic                  in_pool;
  logic                  bit_free;
  logic                  bit_held;
  logic                  idx_last;
  logic [CNT_W-1:0]      free_total;
  logic [CLI_W-1:0]      cli_sel;
  logic [CLI_W-1:0]      in_cli_sel;
  logic [3:0]            in_client;
  logic [7:0]            in_want;
  logic [7:0]            fixed_cnt;
  logic [127:0]          res_cnt_all;
  logic                  in_client_ok;

  assign in_client    = in_tdata[3:0];
  assign in_want      = in_tdata[11:4];
  assign in_cli_sel   = in_client[CLI_W-1:0];
  assign cli_sel      = client_r[CLI_W-1:0];
  assign in_client_ok = {1'b0, in_client} < 5'(NUM_CLIENTS);
  assign res_cnt_all  = {res_cnt_hi_r, res_cnt_lo_r};
  assign fixed_cnt    = res_cnt_all[{in_client, 3'b000} +: 8];

  assign pool_size = (block_count_r > 7'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                      : block_count_r[CNT_W-1:0];
  assign in_pool   = CNT_W'(idx_r) < pool_size;
  assign bit_free  = in_pool && !used_r[idx_r] && !res_blocks_r[idx_r];
  assign bit_held  = in_pool && client_ok_r && cmap_r[cli_sel][idx_r];
  assign idx_last  = idx_r == BLK_W'(NUM_BLOCKS - 1);
  assign free_total = free_cnt_r + CNT_W'(bit_free);

  assign in_tready  = state_r == S_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = state_r == S_DONE;
  assign out_tdata  = {2'b00, 7'(free_cnt_r), 7'(held_cnt_r)};
  assign out_tuser  = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      block_count_r <= BLOCK_COUNT_RESET;
      res_blocks_r  <= '0;
      res_cnt_lo_r  <= '0;
      res_cnt_hi_r  <= '0;
      used_r        <= '0;
      for (int c = 0; c < NUM_CLIENTS; c++) begin
        cmap_r[c] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      block_count_r <= block_count_nxt;
      res_blocks_r  <= res_blocks_nxt;
      res_cnt_lo_r  <= res_cnt_lo_nxt;
      res_cnt_hi_r  <= res_cnt_hi_nxt;
      used_r        <= used_nxt;
      for (int c = 0; c < NUM_CLIENTS; c++) begin
        cmap_r[c] <= cmap_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    client_r    <= client_nxt;
    client_ok_r <= client_ok_nxt;
    need_r      <= need_nxt;
    idx_r       <= idx_nxt;
    free_cnt_r  <= free_cnt_nxt;
    held_cnt_r  <= held_cnt_nxt;
    status_r    <= status_nxt;
  end

  always_comb begin
    block_count_nxt = block_count_r;
    res_blocks_nxt  = res_blocks_r;
    res_cnt_lo_nxt  = res_cnt_lo_r;
    res_cnt_hi_nxt  = res_cnt_hi_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BLOCK_COUNT: block_count_nxt = cfg_data[6:0];
        CFG_RES_BLOCKS:  res_blocks_nxt  = cfg_data;
        CFG_RES_CNT_LO:  res_cnt_lo_nxt  = cfg_data;
        CFG_RES_CNT_HI:  res_cnt_hi_nxt  = cfg_data;
        default:         block_count_nxt = block_count_r;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    cmap_nxt      = cmap_r;
    client_nxt    = client_r;
    client_ok_nxt = client_ok_r;
    need_nxt      = need_r;
    idx_nxt       = idx_r;
    free_cnt_nxt  = free_cnt_r;
    held_cnt_nxt  = held_cnt_r;
    status_nxt    = status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          client_nxt    = in_client;
          client_ok_nxt = in_client_ok;
          need_nxt      = (in_want > fixed_cnt) ? in_want - fixed_cnt : 8'd0;
          status_nxt    = STATUS_OK;
          idx_nxt       = '0;
          free_cnt_nxt  = '0;
          held_cnt_nxt  = '0;
          if (in_client_ok && cmd_t'(in_tuser[0]) == CMD_REQUEST) begin
            state_nxt = S_FREE;
          end else begin
            if (in_client_ok) begin
              used_nxt             = used_r & ~cmap_r[in_cli_sel];
              cmap_nxt[in_cli_sel] = '0;
            end
            state_nxt = S_COUNT;
          end
        end
      end
      S_FREE: begin
        free_cnt_nxt = free_total;
        idx_nxt      = idx_r + BLK_W'(1);
        if (idx_last) begin
          idx_nxt      = '0;
          free_cnt_nxt = '0;
          if (need_r > 8'(free_total)) begin
            status_nxt = STATUS_NO_SPACE;
            state_nxt  = S_COUNT;
          end else begin
            state_nxt = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        if (need_r == 8'd0) begin
          idx_nxt   = '0;
          state_nxt = S_COUNT;
        end else begin
          if (bit_free) begin
            used_nxt[idx_r]          = 1'b1;
            cmap_nxt[cli_sel][idx_r] = 1'b1;
            need_nxt                 = need_r - 8'd1;
          end
          idx_nxt = idx_r + BLK_W'(1);
          if (idx_last) begin
            idx_nxt   = '0;
            state_nxt = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        free_cnt_nxt = free_total;
        held_cnt_nxt = held_cnt_r + CNT_W'(bit_held);
        idx_nxt      = idx_r + BLK_W'(1);
        if (idx_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule : pooled_block_bitmap_allocator
`default_nettype wire

FILE: test/pooled_block_bitmap_allocator_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pooled block bitmap allocator checker
// Watches the input, result and register write channels of the allocator.
// It keeps its own copy of the used map, the per-client maps and the
// registers, and works out the result of every accepted command. Each
// result transfer is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module pooled_block_bitmap_allocator_chk
  import pbba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    status_t    status;
    logic [6:0] held;
    logic [6:0] free;
  } alloc_result_t;

  logic [6:0]    block_count_q;
  logic [63:0]   reserved_map;
  logic [63:0]   fixed_lo;
  logic [63:0]   fixed_hi;
  logic [63:0]   used_map;
  logic [63:0]   client_map [NUM_CLIENTS];
  alloc_result_t expected_results [$];
  int            mismatches = 0;
  int            results_seen = 0;

  function automatic int unsigned pool_len();
    return (block_count_q > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_count_q);
  endfunction

  function automatic logic [63:0] pool_mask();
    if (pool_len() >= 64) return '1;
    return (64'd1 << pool_len()) - 64'd1;
  endfunction

  function automatic int unsigned free_now();
    return $countones(~(used_map | reserved_map) & pool_mask());
  endfunction

  task automatic predict_allocation(input cmd_t cmd, input logic [3:0] cli,
                                    input logic [7:0] want);
    alloc_result_t r;
    int unsigned   fixed;
    int unsigned   need;
    r.status = STATUS_OK;
    r.held   = '0;
    if (int'(cli) < NUM_CLIENTS) begin
      if (cmd == CMD_RELEASE) begin
        used_map &= ~client_map[cli];
        client_map[cli] = '0;
      end else begin
        fixed = cli[3] ? fixed_hi[8*cli[2:0] +: 8] : fixed_lo[8*cli[2:0] +: 8];
        need  = (want > fixed) ? want - fixed : 0;
        if (need > free_now()) begin
          r.status = STATUS_NO_SPACE;
        end else begin
          for (int i = 0; i < int'(pool_len()) && need > 0; i++) begin
            if (!(used_map[i] | reserved_map[i])) begin
              used_map[i]         = 1'b1;
              client_map[cli][i]  = 1'b1;
              need--;
            end
          end
        end
      end
      r.held = 7'($countones(client_map[cli] & pool_mask()));
    end
    r.free = 7'(free_now());
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin : monitor
    alloc_result_t got;
    alloc_result_t exp_r;
    if (!rst_n) begin
      block_count_q = BLOCK_COUNT_RESET;
      reserved_map  = '0;
      fixed_lo      = '0;
      fixed_hi      = '0;
      used_map      = '0;
      foreach (client_map[i]) client_map[i] = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BLOCK_COUNT: block_count_q = cfg_data[6:0];
          CFG_RES_BLOCKS:  reserved_map  = cfg_data;
          CFG_RES_CNT_LO:  fixed_lo      = cfg_data;
          CFG_RES_CNT_HI:  fixed_hi      = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_allocation(cmd_t'(in_tuser[0]), in_tdata[3:0], in_tdata[11:4]);
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser[0]);
        got.held   = out_tdata[6:0];
        got.free   = out_tdata[13:7];
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with none expected: status %0d held %0d free %0d",
                     $realtime, got.status, got.held, got.free);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status != exp_r.status || got.held != exp_r.held ||
              got.free != exp_r.free) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected status %0d held %0d free %0d, got status %0d held %0d free %0d",
                       $realtime, exp_r.status, exp_r.held, exp_r.free,
                       got.status, got.held, got.free);
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_results.size();
    checked    <= results_seen;
  end

endmodule

FILE: test/pooled_block_bitmap_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pooled block bitmap allocator testbench
// Drives request and release commands and register settings into the
// allocator, stalls both stream sides at random, and leaves the checking to
// the checker module beside the block. Directed commands cover full and
// empty pools, shrunk and saturated pool sizes, reserved blocks and fixed
// per-client counts; random phases follow under several register settings.
// ----------------------------------------------------------------------------
module pooled_block_bitmap_allocator_tb;
  import pbba_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int DRAIN_CYCLES    = 200;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // client[3:0], want_blocks[11:4], zero[15:12]
  logic [0:0]  in_tuser;   // cmd[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // client_blocks[6:0], free_blocks[13:7], zero[15:14]
  logic [0:0]  out_tuser;  // status[0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  int   fail_count;
  int   pending;
  int   checked;
  int   cycles = 0;
  int   items_sent = 0;
  int   cfg_writes = 0;
  logic steady;

  always #(CLK_HALF) clk = ~clk;

  pooled_block_bitmap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pooled_block_bitmap_allocator_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [3:0] cli, input logic [7:0] want);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 32) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, want, cli};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Holds off the sender until every expected result has been transferred.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  task automatic program_pool(input logic [6:0] blocks, input logic [63:0] reserved,
                              input logic [63:0] fixed_lo, input logic [63:0] fixed_hi);
    write_reg(CFG_BLOCK_COUNT, 64'(blocks));
    write_reg(CFG_RES_BLOCKS, reserved);
    write_reg(CFG_RES_CNT_LO, fixed_lo);
    write_reg(CFG_RES_CNT_HI, fixed_hi);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] small_counts();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = 8'($urandom_range(0, 3));
    return v;
  endfunction

  task automatic random_phase(input int count);
    cmd_t       cmd;
    logic [7:0] want;
    int         pick;
    repeat (count) begin
      cmd  = ($urandom_range(99) < 25) ? CMD_RELEASE : CMD_REQUEST;
      pick = $urandom_range(99);
      if (pick < 70)      want = 8'($urandom_range(0, 12));
      else if (pick < 90) want = 8'($urandom_range(0, 40));
      else                want = 8'($urandom_range(0, 255));
      send_item(cmd, 4'($urandom_range(0, 15)), want);
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_BLOCK_COUNT;
    cfg_data   <= '0;
    steady     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full pool of 64 blocks with nothing reserved.
    send_item(CMD_REQUEST, 4'd0, 8'd0);
    send_item(CMD_REQUEST, 4'd0, 8'd255);
    send_item(CMD_REQUEST, 4'd0, 8'd64);
    send_item(CMD_REQUEST, 4'd1, 8'd1);
    send_item(CMD_REQUEST, 4'd1, 8'd0);
    send_item(CMD_RELEASE, 4'd0, 8'd0);
    send_item(CMD_RELEASE, 4'd0, 8'd17);
    send_item(CMD_REQUEST, 4'd15, 8'd10);
    send_item(CMD_REQUEST, 4'd15, 8'd5);
    send_item(CMD_REQUEST, 4'd3, 8'd20);
    send_item(CMD_RELEASE, 4'd15, 8'd0);
    send_item(CMD_REQUEST, 4'd4, 8'd3);
    drain();

    // Pool shrunk below blocks already handed out.
    program_pool(7'd8, '0, '0, '0);
    send_item(CMD_REQUEST, 4'd3, 8'd0);
    send_item(CMD_RELEASE, 4'd3, 8'd0);
    drain();

    // Empty pool.
    program_pool(7'd0, '0, '0, '0);
    send_item(CMD_REQUEST, 4'd5, 8'd1);
    send_item(CMD_REQUEST, 4'd5, 8'd0);
    drain();

    // Block count beyond the pool saturates.
    program_pool(7'd127, '0, '0, '0);
    send_item(CMD_REQUEST, 4'd6, 8'd61);
    send_item(CMD_RELEASE, 4'd4, 8'd0);
    send_item(CMD_RELEASE, 4'd6, 8'd0);
    drain();

    // Reserved end blocks and fixed per-client counts.
    program_pool(7'd64, 64'h8000_0000_0000_0001, 64'h0000_0000_00FF_0500,
                 64'h0200_0000_0000_0000);
    send_item(CMD_REQUEST, 4'd1, 8'd5);
    send_item(CMD_REQUEST, 4'd1, 8'd8);
    send_item(CMD_REQUEST, 4'd2, 8'd255);
    send_item(CMD_REQUEST, 4'd15, 8'd64);
    send_item(CMD_RELEASE, 4'd15, 8'd0);
    send_item(CMD_RELEASE, 4'd1, 8'd0);
    drain();

    program_pool(7'd64, '0, '0, '0);
    steady <= 1'b1;
    random_phase(ITEMS_PER_PHASE);
    drain();
    steady <= 1'b0;

    program_pool(7'($urandom_range(1, 64)), {$urandom, $urandom} & {$urandom, $urandom},
                 small_counts(), small_counts());
    random_phase(ITEMS_PER_PHASE);
    drain();

    program_pool(7'd1, '0, '0, '0);
    random_phase(ITEMS_PER_PHASE);
    drain();

    program_pool(7'd64, '1, small_counts(), '1);
    random_phase(ITEMS_PER_PHASE);
    drain();

    program_pool(7'd127, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    random_phase(ITEMS_PER_PHASE);
    drain();

    program_pool(7'($urandom_range(0, 127)), {$urandom, $urandom} & {$urandom, $urandom},
                 small_counts(), {$urandom, $urandom});
    random_phase(ITEMS_PER_PHASE);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands across %0d register writes and checked %0d results.",
             items_sent, cfg_writes, checked);
    $display("Settings ranged over empty, one-block, shrunk, saturated and fully reserved pools.");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pbba_pkg.sv
sv/pooled_block_bitmap_allocator.sv
test/pooled_block_bitmap_allocator_chk.sv
test/pooled_block_bitmap_allocator_tb.sv
